>>> hw/rtl/amu_pkg.sv
package amu_pkg;

  localparam int ELEM_W = 32;
  localparam int FRAC = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W = PROD_W + 3;
  localparam int DIV_W = ELEM_W + FRAC;
  localparam int NELEM = 9;

  localparam logic [2:0] OP_LOAD = 3'd0;
  localparam logic [2:0] OP_LMUL = 3'd1;
  localparam logic [2:0] OP_RMUL = 3'd2;
  localparam logic [2:0] OP_INV = 3'd3;
  localparam logic [2:0] OP_TRANS = 3'd4;
  localparam logic [2:0] OP_XFORM = 3'd5;

  localparam logic [2:0] MODE_LMUL = 3'd0;
  localparam logic [2:0] MODE_RMUL = 3'd1;
  localparam logic [2:0] MODE_COF = 3'd2;
  localparam logic [2:0] MODE_DET = 3'd3;
  localparam logic [2:0] MODE_XFORM = 3'd4;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef struct packed {
    logic       capture;
    logic       load;
    logic       trans;
    logic       acc_clr;
    logic       mul;
    logic       acc;
    logic       sub;
    logic       fin;
    logic       copy;
    logic       set_sing;
    logic       div_init;
    logic       div_step;
    logic       div_wr;
    logic [2:0] mode;
    logic [3:0] e;
    logic [1:0] k;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
  } status_t;

  function automatic logic [1:0] row_of(input logic [3:0] e);
    case (e)
      4'd0, 4'd1, 4'd2: row_of = 2'd0;
      4'd3, 4'd4, 4'd5: row_of = 2'd1;
      default:          row_of = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] col_of(input logic [3:0] e);
    case (e)
      4'd0, 4'd3, 4'd6: col_of = 2'd0;
      4'd1, 4'd4, 4'd7: col_of = 2'd1;
      default:          col_of = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] inc3(input logic [1:0] v);
    inc3 = (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  function automatic logic [3:0] idx(input logic [1:0] r, input logic [1:0] c);
    idx = {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
  endfunction

  function automatic elem_t sat_elem(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'({1'b0, {(ELEM_W-1){1'b1}}});
    lo = -hi - ACC_W'(1);
    if (v > hi) sat_elem = hi[ELEM_W-1:0];
    else if (v < lo) sat_elem = lo[ELEM_W-1:0];
    else sat_elem = v[ELEM_W-1:0];
  endfunction

endpackage

>>> hw/rtl/affine_matrix_unit.sv
// 3x3 transform matrix unit, signed Q16.16 elements, matrix reset to identity
// input channel: in_valid / in_stall carry one word of operation, operand
// matrix a00..a22 and point_x/point_y; a word is taken when valid and not stalled
// result channel: out_valid / out_stall carry the matrix after the step,
// out_x/out_y (transform point only, else zero) and out_singular
// one word is in flight at a time; in_stall stays high until the result is taken
// the single 32x32 multiplier forms one product term at a time, and the
// one-bit-per-cycle divider takes 48 steps per element of an inverse;
// invert stops before dividing if the determinant is zero (singular)
// reset (rst_n low, synchronous) restores identity and drops out_valid
// a stalled result holds all outputs until out_stall falls
module affine_matrix_unit import amu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic signed [31:0] in_a00,
  input  logic signed [31:0] in_a01,
  input  logic signed [31:0] in_a02,
  input  logic signed [31:0] in_a10,
  input  logic signed [31:0] in_a11,
  input  logic signed [31:0] in_a12,
  input  logic signed [31:0] in_a20,
  input  logic signed [31:0] in_a21,
  input  logic signed [31:0] in_a22,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_r00,
  output logic signed [31:0] out_r01,
  output logic signed [31:0] out_r02,
  output logic signed [31:0] out_r10,
  output logic signed [31:0] out_r11,
  output logic signed [31:0] out_r12,
  output logic signed [31:0] out_r20,
  output logic signed [31:0] out_r21,
  output logic signed [31:0] out_r22,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic        out_singular
);

  cmd_t cmd;
  status_t status;
  elem_t a_in [NELEM];
  elem_t m_out [NELEM];

  assign a_in[0] = in_a00;
  assign a_in[1] = in_a01;
  assign a_in[2] = in_a02;
  assign a_in[3] = in_a10;
  assign a_in[4] = in_a11;
  assign a_in[5] = in_a12;
  assign a_in[6] = in_a20;
  assign a_in[7] = in_a21;
  assign a_in[8] = in_a22;

  amu_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .cmd          (cmd)
  );

  amu_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .a_in     (a_in),
    .px_in    (in_point_x),
    .py_in    (in_point_y),
    .m_out    (m_out),
    .ox_out   (out_x),
    .oy_out   (out_y),
    .sing_out (out_singular)
  );

  assign out_r00 = m_out[0];
  assign out_r01 = m_out[1];
  assign out_r02 = m_out[2];
  assign out_r10 = m_out[3];
  assign out_r11 = m_out[4];
  assign out_r12 = m_out[5];
  assign out_r20 = m_out[6];
  assign out_r21 = m_out[7];
  assign out_r22 = m_out[8];

endmodule

>>> hw/rtl/amu_ctrl.sv
module amu_ctrl import amu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_operation,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  status_t    status,
  output cmd_t       cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_CLR = 4'd2;
  localparam logic [3:0] S_MUL = 4'd3;
  localparam logic [3:0] S_ACC = 4'd4;
  localparam logic [3:0] S_FIN = 4'd5;
  localparam logic [3:0] S_COPY = 4'd6;
  localparam logic [3:0] S_DCHK = 4'd7;
  localparam logic [3:0] S_DINIT = 4'd8;
  localparam logic [3:0] S_DSTEP = 4'd9;
  localparam logic [3:0] S_DWR = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  localparam logic [5:0] DIV_LAST = 6'(DIV_W - 1);

  logic [3:0] state_r, state_nxt;
  logic [3:0] e_r, e_nxt;
  logic [5:0] k_r, k_nxt;
  logic [2:0] mode_r, mode_nxt;
  logic [2:0] op_r, op_nxt;
  logic [1:0] k_last;
  logic [3:0] e_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      e_r <= '0;
      k_r <= '0;
      mode_r <= MODE_LMUL;
      op_r <= OP_LOAD;
    end else begin
      state_r <= state_nxt;
      e_r <= e_nxt;
      k_r <= k_nxt;
      mode_r <= mode_nxt;
      op_r <= op_nxt;
    end
  end

  always_comb begin
    case (mode_r)
      MODE_COF:   begin k_last = 2'd1; e_last = 4'd8; end
      MODE_DET:   begin k_last = 2'd2; e_last = 4'd0; end
      MODE_XFORM: begin k_last = 2'd1; e_last = 4'd1; end
      default:    begin k_last = 2'd2; e_last = 4'd8; end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    state_nxt = state_r;
    e_nxt = e_r;
    k_nxt = k_r;
    mode_nxt = mode_r;
    op_nxt = op_r;
    cmd = '0;
    cmd.mode = mode_r;
    cmd.e = e_r;
    cmd.k = k_r[1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          op_nxt = in_operation;
          state_nxt = S_START;
        end
      end
      S_START: begin
        e_nxt = '0;
        k_nxt = '0;
        case (op_r)
          OP_LOAD:  begin cmd.load = 1'b1; state_nxt = S_DONE; end
          OP_TRANS: begin cmd.trans = 1'b1; state_nxt = S_DONE; end
          OP_LMUL:  begin mode_nxt = MODE_LMUL; state_nxt = S_CLR; end
          OP_RMUL:  begin mode_nxt = MODE_RMUL; state_nxt = S_CLR; end
          OP_INV:   begin mode_nxt = MODE_COF; state_nxt = S_CLR; end
          OP_XFORM: begin mode_nxt = MODE_XFORM; state_nxt = S_CLR; end
          default:  state_nxt = S_DONE;
        endcase
      end
      S_CLR: begin
        cmd.acc_clr = 1'b1;
        k_nxt = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        cmd.sub = (mode_r == MODE_COF) && (k_r[1:0] == 2'd1);
        if (k_r[1:0] == k_last) state_nxt = S_FIN;
        else begin
          k_nxt = k_r + 6'd1;
          state_nxt = S_MUL;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (e_r == e_last) begin
          e_nxt = '0;
          case (mode_r)
            MODE_COF: begin mode_nxt = MODE_DET; state_nxt = S_CLR; end
            MODE_DET:   state_nxt = S_DCHK;
            MODE_XFORM: state_nxt = S_DONE;
            default:    state_nxt = S_COPY;
          endcase
        end else begin
          e_nxt = e_r + 4'd1;
          state_nxt = S_CLR;
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        state_nxt = S_DONE;
      end
      S_DCHK: begin
        e_nxt = '0;
        if (status.det_zero) begin
          cmd.set_sing = 1'b1;
          state_nxt = S_DONE;
        end else state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        k_nxt = '0;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        if (k_r == DIV_LAST) state_nxt = S_DWR;
        else k_nxt = k_r + 6'd1;
      end
      S_DWR: begin
        cmd.div_wr = 1'b1;
        if (e_r == 4'(NELEM - 1)) state_nxt = S_DONE;
        else begin
          e_nxt = e_r + 4'd1;
          state_nxt = S_DINIT;
        end
      end
      S_DONE: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/amu_dp.sv
module amu_dp import amu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_t    cmd,
  output status_t status,
  input  elem_t   a_in [NELEM],
  input  elem_t   px_in,
  input  elem_t   py_in,
  output elem_t   m_out [NELEM],
  output elem_t   ox_out,
  output elem_t   oy_out,
  output logic    sing_out
);

  elem_t m_r [NELEM];
  elem_t opnd_r [NELEM];
  elem_t tmp_r [NELEM];
  elem_t px_r, py_r, det_r, ox_r, oy_r;
  logic sing_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [DIV_W-1:0] dq_r;
  logic [ELEM_W-1:0] rem_r;
  logic neg_r;

  logic [1:0] ri, cj, r1, r2, c1, c2;
  elem_t mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] rnd, qs, clr_val;
  elem_t fin_val, div_val;
  logic [ELEM_W-1:0] dmag, nmag;
  logic [ELEM_W:0] rs, rdiff;
  elem_t cur_tmp;

  assign ri = row_of(cmd.e);
  assign cj = col_of(cmd.e);
  assign r1 = inc3(ri);
  assign r2 = inc3(r1);
  assign c1 = inc3(cj);
  assign c2 = inc3(c1);

  always_comb begin
    case (cmd.mode)
      MODE_LMUL: begin
        mul_a = opnd_r[idx(ri, cmd.k)];
        mul_b = m_r[idx(cmd.k, cj)];
      end
      MODE_RMUL: begin
        mul_a = m_r[idx(ri, cmd.k)];
        mul_b = opnd_r[idx(cmd.k, cj)];
      end
      MODE_COF: begin
        if (cmd.k == 2'd0) begin
          mul_a = m_r[idx(r1, c1)];
          mul_b = m_r[idx(r2, c2)];
        end else begin
          mul_a = m_r[idx(r1, c2)];
          mul_b = m_r[idx(r2, c1)];
        end
      end
      MODE_DET: begin
        mul_a = m_r[idx(2'd0, cmd.k)];
        mul_b = tmp_r[idx(2'd0, cmd.k)];
      end
      default: begin
        mul_a = m_r[idx(cmd.e[1:0], cmd.k)];
        mul_b = (cmd.k == 2'd0) ? px_r : py_r;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign clr_val = (cmd.mode == MODE_XFORM) ?
                   (ACC_W'(m_r[idx(cmd.e[1:0], 2'd2)]) <<< FRAC) : '0;
  assign rnd = (acc_r + (ACC_W'(1) <<< (FRAC - 1))) >>> FRAC;
  assign fin_val = sat_elem(rnd);

  // restoring divide on magnitudes
  assign cur_tmp = tmp_r[cmd.e];
  assign nmag = cur_tmp[ELEM_W-1] ? ELEM_W'(-cur_tmp) : ELEM_W'(cur_tmp);
  assign dmag = det_r[ELEM_W-1] ? ELEM_W'(-det_r) : ELEM_W'(det_r);
  assign rs = {rem_r, dq_r[DIV_W-1]};
  assign rdiff = rs - {1'b0, dmag};
  assign qs = neg_r ? -ACC_W'(dq_r) : ACC_W'(dq_r);
  assign div_val = sat_elem(qs);

  assign status.det_zero = (det_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < NELEM; n++) begin
        m_r[n] <= (n % 4 == 0) ? (ELEM_W'(1) <<< FRAC) : '0;
      end
      ox_r <= '0;
      oy_r <= '0;
      sing_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        ox_r <= '0;
        oy_r <= '0;
        sing_r <= 1'b0;
      end
      if (cmd.load) m_r <= opnd_r;
      if (cmd.copy) m_r <= tmp_r;
      if (cmd.trans) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            m_r[r * 3 + c] <= m_r[c * 3 + r];
          end
        end
      end
      if (cmd.fin && cmd.mode == MODE_XFORM) begin
        if (cmd.e[0]) oy_r <= fin_val;
        else ox_r <= fin_val;
      end
      if (cmd.set_sing) sing_r <= 1'b1;
      if (cmd.div_wr) m_r[idx(cj, ri)] <= div_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      opnd_r <= a_in;
      px_r <= px_in;
      py_r <= py_in;
    end
    if (cmd.mul) prod_r <= prod;
    if (cmd.acc_clr) acc_r <= clr_val;
    else if (cmd.acc) begin
      if (cmd.sub) acc_r <= acc_r - ACC_W'(prod_r);
      else acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (cmd.fin) begin
      if (cmd.mode == MODE_DET) det_r <= fin_val;
      else if (cmd.mode != MODE_XFORM) tmp_r[cmd.e] <= fin_val;
    end
    if (cmd.div_init) begin
      dq_r <= {nmag, {FRAC{1'b0}}};
      rem_r <= '0;
      neg_r <= cur_tmp[ELEM_W-1] ^ det_r[ELEM_W-1];
    end else if (cmd.div_step) begin
      if (!rdiff[ELEM_W]) begin
        rem_r <= rdiff[ELEM_W-1:0];
        dq_r <= {dq_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= rs[ELEM_W-1:0];
        dq_r <= {dq_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign m_out = m_r;
  assign ox_out = ox_r;
  assign oy_out = oy_r;
  assign sing_out = sing_r;

endmodule
